// ===== hw/rtl/qer_pkg.sv =====
package qer_pkg;

    // default configuration of the evaluator
    localparam int COEF_WIDTH_DEF     = 16;
    localparam int SQRT_FRAC_BITS_DEF = 16;

    // bit positions of the flags on the result tuser
    localparam int TUSER_NOT_REAL   = 0;
    localparam int TUSER_DEGENERATE = 1;
    localparam int TUSER_WIDTH      = 2;

endpackage

// ===== hw/rtl/qer_front.sv =====
module qer_front #(
    parameter int COEF_WIDTH = qer_pkg::COEF_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           en,
    input  logic signed [COEF_WIDTH-1:0]   coef_a,
    input  logic signed [COEF_WIDTH-1:0]   coef_b,
    input  logic signed [COEF_WIDTH-1:0]   coef_c,
    input  logic signed [COEF_WIDTH-1:0]   point_x,
    output logic signed [3*COEF_WIDTH-2:0] poly_value,
    output logic signed [2*COEF_WIDTH+1:0] disc,
    output logic signed [COEF_WIDTH-1:0]   a_out,
    output logic signed [COEF_WIDTH-1:0]   b_out
);
    import qer_pkg::*;

    localparam int CW = COEF_WIDTH;
    localparam int PW = 3 * CW - 1;
    localparam int DW = 2 * CW + 2;

    logic signed [2*CW-1:0] ax_reg, bx_reg, bb_reg, ac_reg;
    logic signed [CW-1:0]   a1_reg, b1_reg, c1_reg, x1_reg;
    logic signed [3*CW-1:0] axx_reg;
    logic signed [2*CW:0]   bxc_reg;
    logic signed [DW-1:0]   d2_reg, d3_reg;
    logic signed [CW-1:0]   a2_reg, b2_reg, a3_reg, b3_reg;
    logic signed [PW-1:0]   poly_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            // products
            ax_reg  <= coef_a * point_x;
            bx_reg  <= coef_b * point_x;
            bb_reg  <= coef_b * coef_b;
            ac_reg  <= coef_a * coef_c;
            a1_reg  <= coef_a;
            b1_reg  <= coef_b;
            c1_reg  <= coef_c;
            x1_reg  <= point_x;
            // second product and discriminant
            axx_reg <= ax_reg * x1_reg;
            bxc_reg <= bx_reg + c1_reg;
            d2_reg  <= DW'(bb_reg) - (DW'(ac_reg) <<< 2);
            a2_reg  <= a1_reg;
            b2_reg  <= b1_reg;
            // final sum
            poly_reg <= PW'(axx_reg + bxc_reg);
            d3_reg   <= d2_reg;
            a3_reg   <= a2_reg;
            b3_reg   <= b2_reg;
        end
    end

    assign poly_value = poly_reg;
    assign disc       = d3_reg;
    assign a_out      = a3_reg;
    assign b_out      = b3_reg;

endmodule

// ===== hw/rtl/qer_sqrt_cell.sv =====
module qer_sqrt_cell #(
    parameter int ROOT_W = 33
) (
    input  logic                aclk,
    input  logic                en,
    input  logic [2*ROOT_W-1:0] rad_in,
    input  logic [ROOT_W+2:0]   rem_in,
    input  logic [ROOT_W-1:0]   root_in,
    output logic [2*ROOT_W-1:0] rad_out,
    output logic [ROOT_W+2:0]   rem_out,
    output logic [ROOT_W-1:0]   root_out
);
    import qer_pkg::*;

    localparam int RADW = 2 * ROOT_W;
    localparam int REMW = ROOT_W + 3;

    logic [RADW-1:0] rad_reg;
    logic [REMW-1:0] rem_reg, rem_sh, trial, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic            ge;

    always_comb begin
        // bring down the next pair of radicand bits
        rem_sh    = {rem_in[REMW-3:0], rad_in[RADW-1 -: 2]};
        trial     = REMW'({root_in, 2'b01});
        ge        = rem_sh >= trial;
        rem_next  = ge ? rem_sh - trial : rem_sh;
        root_next = {root_in[ROOT_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg  <= rad_in << 2;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign rad_out  = rad_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

// ===== hw/rtl/qer_div_cell.sv =====
module qer_div_cell #(
    parameter int NUM_W = 18,
    parameter int DIV_W = 16
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [NUM_W-1:0] nq_in,
    input  logic [DIV_W-1:0] rem_in,
    input  logic [DIV_W-1:0] dv_in,
    output logic [NUM_W-1:0] nq_out,
    output logic [DIV_W-1:0] rem_out,
    output logic [DIV_W-1:0] dv_out
);
    import qer_pkg::*;

    logic [NUM_W-1:0] nq_reg;
    logic [DIV_W-1:0] rem_reg, dv_reg;
    logic [DIV_W:0]   rem_sh, rem_sub;
    logic             ge;

    always_comb begin
        // shift in the next numerator bit, quotient bit fills from the bottom
        rem_sh  = {rem_in, nq_in[NUM_W-1]};
        ge      = rem_sh >= {1'b0, dv_in};
        rem_sub = ge ? rem_sh - {1'b0, dv_in} : rem_sh;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nq_reg  <= {nq_in[NUM_W-2:0], ge};
            rem_reg <= rem_sub[DIV_W-1:0];
            dv_reg  <= dv_in;
        end
    end

    assign nq_out  = nq_reg;
    assign rem_out = rem_reg;
    assign dv_out  = dv_reg;

endmodule

// ===== hw/rtl/quadratic_eval_and_roots.sv =====
// Quadratic evaluator and root finder.
// Input item on s_axis: coefficients a, b, c and a point x. One result item
// on m_axis per input item: a*x*x+b*x+c exactly, both roots of a*x*x+b*x+c=0
// truncated toward zero, and two flags in tuser. A zero coefficient a raises
// degenerate; otherwise a negative discriminant raises not_real. Either flag
// clears the roots. The square root carries SQRT_FRAC_BITS fractional bits
// before the divide. Throughput: one item per cycle while the receiver does
// not stall. The pipe from accept to m_tvalid is three multiply stages, the
// square-root cell row (one root bit per cell, COEF_WIDTH+1+SQRT_FRAC_BITS
// cells), one root-numerator stage, the divider cell row (one quotient bit
// per cell, COEF_WIDTH+2 cells) and the output register.
// The whole pipe advances together: when the receiver stalls with a result
// waiting, s_tready drops and every stage holds. Reset (aresetn low on a
// clock edge) empties the pipe; in-flight items are dropped.
module quadratic_eval_and_roots #(
    parameter int COEF_WIDTH     = qer_pkg::COEF_WIDTH_DEF,
    parameter int SQRT_FRAC_BITS = qer_pkg::SQRT_FRAC_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // coef_a, coef_b, coef_c, point_x
    input  logic [((4*COEF_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // poly_value, root_plus, root_minus
    output logic [((5*COEF_WIDTH+1+7)/8)*8-1:0] m_tdata,
    // not_real, degenerate
    output logic [qer_pkg::TUSER_WIDTH-1:0] m_tuser
);
    import qer_pkg::*;

    localparam int CW   = COEF_WIDTH;
    localparam int F    = SQRT_FRAC_BITS;
    localparam int PW   = 3 * CW - 1;
    localparam int DW   = 2 * CW + 2;
    localparam int RW   = CW + 1 + F;
    localparam int RADW = 2 * RW;
    localparam int REMW = RW + 3;
    localparam int NW   = CW + F + 3;
    localparam int QW   = CW + 2;
    localparam int RB   = CW + 1;
    localparam int LAT  = RW + QW + 5;
    localparam int MDW  = ((5 * CW + 1 + 7) / 8) * 8;

    typedef struct packed {
        logic signed [CW-1:0] a;
        logic signed [CW-1:0] b;
        logic                 d_neg;
        logic [PW-1:0]        poly;
    } side_sqrt_t;

    typedef struct packed {
        logic [PW-1:0] poly;
        logic          not_real;
        logic          degenerate;
        logic          neg_p;
        logic          neg_m;
    } side_div_t;

    logic en;
    logic [LAT-1:0] vld_reg, vld_next;

    logic signed [PW-1:0] f_poly;
    logic signed [DW-1:0] f_disc;
    logic signed [CW-1:0] f_a, f_b;

    logic [RADW-1:0]  rad_w  [0:RW];
    logic [REMW-1:0]  srem_w [0:RW];
    logic [RW-1:0]    root_w [0:RW];
    side_sqrt_t       side1_reg [0:RW-1];

    logic signed [NW-1:0] nb, sx, np, nm, ap, am;
    logic [QW-1:0]   mp_reg, mm_reg;
    logic [CW-1:0]   dv_reg;
    side_div_t       nside_reg;

    logic [QW-1:0]   pq_w  [0:QW];
    logic [QW-1:0]   mq_w  [0:QW];
    logic [CW-1:0]   prem_w [0:QW];
    logic [CW-1:0]   mrem_w [0:QW];
    logic [CW-1:0]   pdv_w [0:QW];
    logic [CW-1:0]   mdv_w [0:QW];
    side_div_t       side2_reg [0:QW-1];

    logic [QW-1:0]   qp_s, qm_s;
    logic [MDW-1:0]  tdata_reg;
    logic [TUSER_WIDTH-1:0] tuser_reg;

    assign en       = !vld_reg[LAT-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LAT-1];
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;

    always_comb begin
        vld_next = {vld_reg[LAT-2:0], s_tvalid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    qer_front #(.COEF_WIDTH(CW)) u_front (
        .aclk       (aclk),
        .en         (en),
        .coef_a     (s_tdata[CW-1:0]),
        .coef_b     (s_tdata[2*CW-1:CW]),
        .coef_c     (s_tdata[3*CW-1:2*CW]),
        .point_x    (s_tdata[4*CW-1:3*CW]),
        .poly_value (f_poly),
        .disc       (f_disc),
        .a_out      (f_a),
        .b_out      (f_b)
    );

    // negative discriminant is flagged later; feed the root row with zero
    assign rad_w[0]  = f_disc[DW-1] ? '0 : (RADW'(unsigned'(f_disc)) << (2 * F));
    assign srem_w[0] = '0;
    assign root_w[0] = '0;

    for (genvar i = 0; i < RW; i++) begin : g_sqrt
        qer_sqrt_cell #(.ROOT_W(RW)) u_cell (
            .aclk     (aclk),
            .en       (en),
            .rad_in   (rad_w[i]),
            .rem_in   (srem_w[i]),
            .root_in  (root_w[i]),
            .rad_out  (rad_w[i+1]),
            .rem_out  (srem_w[i+1]),
            .root_out (root_w[i+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side1_reg[0] <= '{a: f_a, b: f_b, d_neg: f_disc[DW-1], poly: f_poly};
            for (int i = 1; i < RW; i++) begin
                side1_reg[i] <= side1_reg[i-1];
            end
        end
    end

    // numerators (-b*2^F +/- s); magnitude scaled down by 2^(F+1) before the divide
    always_comb begin
        nb = -(NW'(side1_reg[RW-1].b) <<< F);
        sx = signed'(NW'(root_w[RW]));
        np = nb + sx;
        nm = nb - sx;
        ap = np[NW-1] ? -np : np;
        am = nm[NW-1] ? -nm : nm;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mp_reg <= ap[NW-1:F+1];
            mm_reg <= am[NW-1:F+1];
            dv_reg <= side1_reg[RW-1].a[CW-1] ? CW'(-side1_reg[RW-1].a)
                                              : CW'(side1_reg[RW-1].a);
            nside_reg.poly       <= side1_reg[RW-1].poly;
            nside_reg.degenerate <= side1_reg[RW-1].a == '0;
            nside_reg.not_real   <= side1_reg[RW-1].d_neg && side1_reg[RW-1].a != '0;
            nside_reg.neg_p      <= np[NW-1] ^ side1_reg[RW-1].a[CW-1];
            nside_reg.neg_m      <= nm[NW-1] ^ side1_reg[RW-1].a[CW-1];
        end
    end

    assign pq_w[0]   = mp_reg;
    assign mq_w[0]   = mm_reg;
    assign prem_w[0] = '0;
    assign mrem_w[0] = '0;
    assign pdv_w[0]  = dv_reg;
    assign mdv_w[0]  = dv_reg;

    for (genvar j = 0; j < QW; j++) begin : g_div
        qer_div_cell #(.NUM_W(QW), .DIV_W(CW)) u_plus (
            .aclk    (aclk),
            .en      (en),
            .nq_in   (pq_w[j]),
            .rem_in  (prem_w[j]),
            .dv_in   (pdv_w[j]),
            .nq_out  (pq_w[j+1]),
            .rem_out (prem_w[j+1]),
            .dv_out  (pdv_w[j+1])
        );
        qer_div_cell #(.NUM_W(QW), .DIV_W(CW)) u_minus (
            .aclk    (aclk),
            .en      (en),
            .nq_in   (mq_w[j]),
            .rem_in  (mrem_w[j]),
            .dv_in   (mdv_w[j]),
            .nq_out  (mq_w[j+1]),
            .rem_out (mrem_w[j+1]),
            .dv_out  (mdv_w[j+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side2_reg[0] <= nside_reg;
            for (int j = 1; j < QW; j++) begin
                side2_reg[j] <= side2_reg[j-1];
            end
        end
    end

    always_comb begin
        qp_s = side2_reg[QW-1].neg_p ? -pq_w[QW] : pq_w[QW];
        qm_s = side2_reg[QW-1].neg_m ? -mq_w[QW] : mq_w[QW];
        if (side2_reg[QW-1].not_real || side2_reg[QW-1].degenerate) begin
            qp_s = '0;
            qm_s = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tdata_reg <= MDW'({qm_s[RB-1:0], qp_s[RB-1:0], side2_reg[QW-1].poly});
            tuser_reg[TUSER_NOT_REAL]   <= side2_reg[QW-1].not_real;
            tuser_reg[TUSER_DEGENERATE] <= side2_reg[QW-1].degenerate;
        end
    end

endmodule

// ===== hw/rtl/qer_checker.sv =====
module qer_checker #(
    parameter int COEF_WIDTH = qer_pkg::COEF_WIDTH_DEF
) (
    input logic aclk,
    input logic aresetn,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic [((5*COEF_WIDTH+1+7)/8)*8-1:0] m_tdata,
    input logic [qer_pkg::TUSER_WIDTH-1:0] m_tuser
);
    import qer_pkg::*;

    localparam int PW = 3 * COEF_WIDTH - 1;
    localparam int RB = COEF_WIDTH + 1;

    // the pipe is empty right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // the two flags exclude each other
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[TUSER_NOT_REAL] && m_tuser[TUSER_DEGENERATE]))
        else $error("not_real and degenerate both set");

    // a flagged result carries zero roots
    a_zero_roots: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[TUSER_NOT_REAL] || m_tuser[TUSER_DEGENERATE]))
        |-> m_tdata[PW+2*RB-1:PW] == '0)
        else $error("flagged result with nonzero roots");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    // the input side stays open while the output is free
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled with output free");

endmodule

bind quadratic_eval_and_roots qer_checker #(.COEF_WIDTH(COEF_WIDTH)) u_qer_checker (.*);
